// File: src/rmrf_pkg.sv
// ----------------------------------------------------------------------------
// rmrf_pkg
// Shared widths, types and register indexes of the ROI mean and relative flow
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmrf_pkg;

  // Pixel coordinate width and region count width.
  localparam int COORD_BITS = 12;
  localparam int COUNT_BITS = 24;

  localparam int SAMPLE_W  = 16;
  localparam int VALUE_W   = 16;
  localparam int CNT_W     = COUNT_BITS + 1;
  localparam int SUM_W     = SAMPLE_W + COUNT_BITS;
  localparam int SQ_W      = 2 * VALUE_W;
  localparam int FLOW_SH   = 8;
  localparam int CFG_DATA_W = (COORD_BITS > VALUE_W) ? COORD_BITS : VALUE_W;
  localparam int CFG_IDX_W = 3;

  // Shared divider: wide enough for both the mean and the flow division.
  localparam int MEAN_NUM_W = SUM_W + 1;
  localparam int FLOW_NUM_W = SQ_W + FLOW_SH + 1;
  localparam int NUM_W = (MEAN_NUM_W > FLOW_NUM_W) ? MEAN_NUM_W : FLOW_NUM_W;
  localparam int DEN_W = (CNT_W > SQ_W) ? CNT_W : SQ_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  // Stream payload widths, rounded up to whole bytes.
  localparam int S_DATA_W = ((SAMPLE_W + 2 * COORD_BITS + 7) / 8) * 8;
  localparam int M_RAW_W  = 2 * VALUE_W + CNT_W + 1;
  localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [SQ_W-1:0]       sq_t;
  typedef logic [NUM_W-1:0]      num_t;
  typedef logic [DEN_W-1:0]      den_t;
  typedef logic [DEN_W:0]        rem_t;
  typedef logic [DIV_CNT_W-1:0]  div_cnt_t;
  typedef logic [M_DATA_W-1:0]   m_data_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROI_MODE       = 3'd0,
    CFG_RECT_X_FIRST   = 3'd1,
    CFG_RECT_Y_FIRST   = 3'd2,
    CFG_RECT_X_FINAL   = 3'd3,
    CFG_RECT_Y_FINAL   = 3'd4,
    CFG_BASELINE       = 3'd5,
    CFG_BASE_FROM_FIRST = 3'd6
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pix_accept;
    logic pix_last;
    logic mean_start;
    logic mean_take;
    logic sq_base;
    logic sq_mean;
    logic flow_start;
    logic flow_take;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic count_zero;
    logic mean_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: src/roi_mean_relative_flow.sv
// ----------------------------------------------------------------------------
// roi_mean_relative_flow
// Region-of-interest mean contrast and relative flow of a speckle frame.
// ----------------------------------------------------------------------------
// Pixels stream in at one transfer per cycle while a frame is in progress;
// each one in the region (an inclusive rectangle, or the pixels whose mask
// bit is set) adds to a running sum and count. The transfer that carries
// tlast closes the frame: the input then stalls (s_axis_tready low) while a
// shared one-bit-per-cycle divider first forms the rounded mean and then the
// relative flow, baseline squared over mean squared in Q8.8. The dividend is
// 41 bits wide, and the divisions are skipped when the region is empty or
// the mean is zero; the sequence also waits for the result register to be
// free. The result stays in an output register until taken, and pixels of
// the next frame are accepted while it waits. The baseline is either the
// baseline register or the mean of the first frame after arming.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_mean_relative_flow (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [rmrf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rmrf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Pixel stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata, lowest bit up: sample, col, row, zero fill.
  input  wire logic [rmrf_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // tuser: in_mask.
  input  wire logic                              s_axis_tuser,
  // tlast: frame_end.
  input  wire logic                              s_axis_tlast,
  // Result stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata, lowest bit up: mean_value, relative_flow, pixel_count,
  // flow_saturated, zero fill.
  output rmrf_pkg::m_data_t                      m_axis_tdata
);

  rmrf_pkg::cmd_t                 cmd;
  rmrf_pkg::status_t              status;
  logic [rmrf_pkg::SAMPLE_W-1:0]  sample;
  rmrf_pkg::coord_t               col, row;
  logic [rmrf_pkg::VALUE_W-1:0]   mean_value, relative_flow;
  rmrf_pkg::cnt_t                 pixel_count;
  logic                           flow_saturated;

  // Unpack the pixel fields from the stream word.
  assign sample = s_axis_tdata[rmrf_pkg::SAMPLE_W-1:0];
  assign col    = s_axis_tdata[rmrf_pkg::SAMPLE_W +: rmrf_pkg::COORD_BITS];
  assign row    = s_axis_tdata[rmrf_pkg::SAMPLE_W + rmrf_pkg::COORD_BITS +:
                               rmrf_pkg::COORD_BITS];

  rmrf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rmrf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .sample_i         (sample),
    .col_i            (col),
    .row_i            (row),
    .in_mask_i        (s_axis_tuser),
    .cmd_i            (cmd),
    .status_o         (status),
    .m_ready_i        (m_axis_tready),
    .m_valid_o        (m_axis_tvalid),
    .mean_value_o     (mean_value),
    .relative_flow_o  (relative_flow),
    .pixel_count_o    (pixel_count),
    .flow_saturated_o (flow_saturated)
  );

  // Pack the result fields, zero-filled to whole bytes.
  assign m_axis_tdata = rmrf_pkg::m_data_t'({flow_saturated, pixel_count,
                                             relative_flow, mean_value});

endmodule

`default_nettype wire

// File: src/rmrf_div.sv
// ----------------------------------------------------------------------------
// rmrf_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by the mean
// and the relative flow division.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrf_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rmrf_pkg::num_t num_i,
  input  wire rmrf_pkg::den_t den_i,
  output logic               done_o,
  output rmrf_pkg::num_t     quo_o
);

  logic               busy_q;
  logic               done_q;
  rmrf_pkg::div_cnt_t cnt_q;
  rmrf_pkg::num_t     nq_q, nq_d;
  rmrf_pkg::rem_t     rem_q, rem_d;
  rmrf_pkg::den_t     den_q;
  rmrf_pkg::rem_t     rem_sh;
  logic               ge;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    rem_sh = {rem_q[rmrf_pkg::DEN_W-1:0], nq_q[rmrf_pkg::NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    nq_d   = {nq_q[rmrf_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == rmrf_pkg::div_cnt_t'(rmrf_pkg::NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      nq_q  <= nq_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while a division is in progress");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a preceding division");

endmodule

`default_nettype wire

// File: src/rmrf_dp.sv
// ----------------------------------------------------------------------------
// rmrf_dp
// Datapath: configuration registers, region accumulators, baseline latch,
// squaring multiplier, shared divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrf_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [rmrf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rmrf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [rmrf_pkg::SAMPLE_W-1:0]     sample_i,
  input  wire rmrf_pkg::coord_t                  col_i,
  input  wire rmrf_pkg::coord_t                  row_i,
  input  wire logic                              in_mask_i,
  input  wire rmrf_pkg::cmd_t                    cmd_i,
  output rmrf_pkg::status_t                      status_o,
  input  wire logic                              m_ready_i,
  output logic                                   m_valid_o,
  output logic [rmrf_pkg::VALUE_W-1:0]           mean_value_o,
  output logic [rmrf_pkg::VALUE_W-1:0]           relative_flow_o,
  output rmrf_pkg::cnt_t                         pixel_count_o,
  output logic                                   flow_saturated_o
);

  // Configuration registers.
  logic                              roi_mode_q;
  rmrf_pkg::coord_t                  x_first_q, y_first_q, x_final_q, y_final_q;
  logic [rmrf_pkg::VALUE_W-1:0]      base_set_q;
  logic                              from_first_q;

  // Accumulators and baseline latch.
  rmrf_pkg::sum_t                    sum_q, sum_new;
  rmrf_pkg::cnt_t                    count_q, count_new;
  logic [rmrf_pkg::VALUE_W-1:0]      latched_q;
  logic                              pending_q;

  // Frame-end working registers.
  rmrf_pkg::sum_t                    sum_snap_q;
  rmrf_pkg::cnt_t                    count_snap_q;
  logic [rmrf_pkg::VALUE_W-1:0]      mean_q, flow_q, base;
  logic                              sat_q;
  rmrf_pkg::sq_t                     bsq_q, msq_q, product;
  logic [rmrf_pkg::VALUE_W-1:0]      sq_in;

  // Divider hookup.
  logic                              div_start, div_done;
  rmrf_pkg::num_t                    div_num, div_quo, mean_num, flow_num;
  rmrf_pkg::den_t                    div_den;
  logic                              quo_over;

  // Result register.
  logic                              out_valid_q;
  logic [rmrf_pkg::VALUE_W-1:0]      out_mean_q, out_flow_q;
  rmrf_pkg::cnt_t                    out_count_q;
  logic                              out_sat_q;

  logic rect_hit, hit, take, count_zero, mean_zero, out_free;

  always_comb begin
    rect_hit = (col_i >= x_first_q) && (col_i <= x_final_q) &&
               (row_i >= y_first_q) && (row_i <= y_final_q);
    hit      = roi_mode_q ? in_mask_i : rect_hit;
    // A full count freezes both accumulators for the rest of the frame.
    take      = hit && !count_q[rmrf_pkg::COUNT_BITS];
    sum_new   = take ? (sum_q + rmrf_pkg::sum_t'(sample_i)) : sum_q;
    count_new = take ? (count_q + 1'b1) : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_mode_q   <= 1'b0;
      x_first_q    <= '0;
      y_first_q    <= '0;
      x_final_q    <= '1;
      y_final_q    <= '1;
      base_set_q   <= '0;
      from_first_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rmrf_pkg::CFG_ROI_MODE:     roi_mode_q <= cfg_data_i[0];
        rmrf_pkg::CFG_RECT_X_FIRST: x_first_q  <= cfg_data_i[rmrf_pkg::COORD_BITS-1:0];
        rmrf_pkg::CFG_RECT_Y_FIRST: y_first_q  <= cfg_data_i[rmrf_pkg::COORD_BITS-1:0];
        rmrf_pkg::CFG_RECT_X_FINAL: x_final_q  <= cfg_data_i[rmrf_pkg::COORD_BITS-1:0];
        rmrf_pkg::CFG_RECT_Y_FINAL: y_final_q  <= cfg_data_i[rmrf_pkg::COORD_BITS-1:0];
        rmrf_pkg::CFG_BASELINE:     base_set_q <= cfg_data_i[rmrf_pkg::VALUE_W-1:0];
        rmrf_pkg::CFG_BASE_FROM_FIRST: from_first_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Accumulators, cleared after the frame's last pixel is snapshotted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.pix_accept) begin
      if (cmd_i.pix_last) begin
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_new;
        count_q <= count_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_accept && cmd_i.pix_last) begin
      sum_snap_q   <= sum_new;
      count_snap_q <= count_new;
    end
  end

  // While pending, the baseline is the mean that is being latched now.
  always_comb begin
    if (from_first_q) begin
      base = pending_q ? mean_q : latched_q;
    end else begin
      base = base_set_q;
    end
    sq_in   = cmd_i.sq_mean ? mean_q : base;
    product = sq_in * sq_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= '0;
      pending_q <= 1'b1;
    end else begin
      if (cfg_we_i && (cfg_idx_i == rmrf_pkg::CFG_BASE_FROM_FIRST) && cfg_data_i[0]) begin
        pending_q <= 1'b1;
      end else if (cmd_i.sq_base && from_first_q && pending_q) begin
        latched_q <= mean_q;
        pending_q <= 1'b0;
      end
    end
  end

  always_comb begin
    count_zero = (count_snap_q == '0);
    mean_zero  = (mean_q == '0);
    // Round half up: add half the divisor to the dividend.
    mean_num   = rmrf_pkg::num_t'(sum_snap_q) +
                 rmrf_pkg::num_t'(count_snap_q[rmrf_pkg::CNT_W-1:1]);
    flow_num   = rmrf_pkg::num_t'({bsq_q, {rmrf_pkg::FLOW_SH{1'b0}}}) +
                 rmrf_pkg::num_t'(msq_q[rmrf_pkg::SQ_W-1:1]);
    div_num    = cmd_i.flow_start ? flow_num : mean_num;
    div_den    = cmd_i.flow_start ? rmrf_pkg::den_t'(msq_q) :
                                    rmrf_pkg::den_t'(count_snap_q);
    div_start  = (cmd_i.mean_start && !count_zero) || (cmd_i.flow_start && !mean_zero);
    quo_over   = |div_quo[rmrf_pkg::NUM_W-1:rmrf_pkg::VALUE_W];
  end

  rmrf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_start && count_zero) begin
      mean_q <= '0;
    end else if (cmd_i.mean_take) begin
      mean_q <= quo_over ? '1 : div_quo[rmrf_pkg::VALUE_W-1:0];
    end
    if (cmd_i.sq_base) begin
      bsq_q <= product;
    end
    if (cmd_i.sq_mean) begin
      msq_q <= product;
    end
    if (cmd_i.flow_start && mean_zero) begin
      flow_q <= '0;
      sat_q  <= 1'b0;
    end else if (cmd_i.flow_take) begin
      flow_q <= quo_over ? '1 : div_quo[rmrf_pkg::VALUE_W-1:0];
      sat_q  <= quo_over;
    end
  end

  assign out_free = !out_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_mean_q  <= mean_q;
      out_flow_q  <= flow_q;
      out_count_q <= count_snap_q;
      out_sat_q   <= sat_q;
    end
  end

  assign status_o = '{div_done: div_done, count_zero: count_zero,
                      mean_zero: mean_zero, out_free: out_free};

  assign m_valid_o        = out_valid_q;
  assign mean_value_o     = out_mean_q;
  assign relative_flow_o  = out_flow_q;
  assign pixel_count_o    = out_count_q;
  assign flow_saturated_o = out_sat_q;

  a_count_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[rmrf_pkg::COUNT_BITS] |-> (count_q[rmrf_pkg::COUNT_BITS-1:0] == '0))
    else $error("region count ran past its limit");

  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("loaded result not presented");

  a_sat_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |-> (out_flow_q == '1))
    else $error("saturated flow is not at its maximum");

endmodule

`default_nettype wire

// File: src/rmrf_ctrl.sv
// ----------------------------------------------------------------------------
// rmrf_ctrl
// Controller: accepts pixels and sequences the frame-end computation.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  input  wire logic              s_last_i,
  output logic                   s_ready_o,
  input  wire rmrf_pkg::status_t status_i,
  output rmrf_pkg::cmd_t         cmd_o
);

  typedef enum logic [7:0] {
    ST_ACCUM      = 8'b0000_0001,
    ST_MEAN_START = 8'b0000_0010,
    ST_MEAN_WAIT  = 8'b0000_0100,
    ST_BASE_SQ    = 8'b0000_1000,
    ST_MEAN_SQ    = 8'b0001_0000,
    ST_FLOW_START = 8'b0010_0000,
    ST_FLOW_WAIT  = 8'b0100_0000,
    ST_EMIT       = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        s_ready_o        = 1'b1;
        cmd_o.pix_accept = s_valid_i;
        cmd_o.pix_last   = s_valid_i && s_last_i;
        if (s_valid_i && s_last_i) begin
          state_d = ST_MEAN_START;
        end
      end
      ST_MEAN_START: begin
        cmd_o.mean_start = 1'b1;
        state_d = status_i.count_zero ? ST_BASE_SQ : ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.mean_take = 1'b1;
          state_d = ST_BASE_SQ;
        end
      end
      ST_BASE_SQ: begin
        cmd_o.sq_base = 1'b1;
        state_d = ST_MEAN_SQ;
      end
      ST_MEAN_SQ: begin
        cmd_o.sq_mean = 1'b1;
        state_d = ST_FLOW_START;
      end
      ST_FLOW_START: begin
        cmd_o.flow_start = 1'b1;
        state_d = status_i.mean_zero ? ST_EMIT : ST_FLOW_WAIT;
      end
      ST_FLOW_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.flow_take = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> ((state_q == ST_MEAN_WAIT) || (state_q == ST_FLOW_WAIT)))
    else $error("division finished outside a wait state");

endmodule

`default_nettype wire
